### sv/tlik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics package
// Shared types, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tlik_pkg;

	localparam int COORD_W            = 16;
	localparam int ANGLE_W            = 16;
	localparam int LEN_W              = 15;
	localparam int TLIK_CORDIC_STAGES = 16;
	localparam int CFG_INDEX_W        = 3;
	localparam int ANG_FRAC           = 16;
	localparam int ZW                 = 26;
	localparam int SQ_IN_W            = 50;
	localparam int AT_IN_W            = 26;

	localparam logic [CFG_INDEX_W-1:0] REG_SIDE        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HAND_OFFSET = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LEFT_SX     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_SX    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOULDER_Y  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOULDER_Z  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_LINK_LEN    = 3'd6;

	localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * (1 << ANG_FRAC));

	typedef struct packed {
		logic signed [COORD_W-1:0] target_x;
		logic signed [COORD_W-1:0] target_y;
		logic signed [COORD_W-1:0] target_z;
	} tlik_in_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] shoulder_pitch;
		logic signed [ANGLE_W-1:0] shoulder_yaw;
		logic signed [ANGLE_W-1:0] elbow_pitch;
		logic                      beyond_reach;
	} tlik_out_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
		logic signed [ZW-1:0] v;
		case (i)
			0:       v = ZW'(2949120);
			1:       v = ZW'(1740967);
			2:       v = ZW'(919879);
			3:       v = ZW'(466945);
			4:       v = ZW'(234379);
			5:       v = ZW'(117304);
			6:       v = ZW'(58666);
			7:       v = ZW'(29335);
			8:       v = ZW'(14668);
			9:       v = ZW'(7334);
			10:      v = ZW'(3667);
			11:      v = ZW'(1833);
			12:      v = ZW'(917);
			13:      v = ZW'(458);
			14:      v = ZW'(229);
			15:      v = ZW'(115);
			16:      v = ZW'(57);
			17:      v = ZW'(29);
			18:      v = ZW'(14);
			19:      v = ZW'(7);
			20:      v = ZW'(4);
			21:      v = ZW'(2);
			22:      v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### sv/tlik_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tlik_isqrt #(
	parameter int IN_W = tlik_pkg::SQ_IN_W
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [IN_W-1:0]     value,
	output logic      [IN_W/2-1:0]   root
);
	import tlik_pkg::*;

	localparam int RW = IN_W / 2;

	logic [IN_W-1:0] rem_s  [RW];
	logic [IN_W-1:0] root_s [RW];
	logic [IN_W-1:0] pv     [RW];
	logic [IN_W-1:0] pr     [RW];
	logic [IN_W-1:0] nv     [RW];
	logic [IN_W-1:0] nr     [RW];

	always_comb begin
		for (int k = 0; k < RW; k++) begin
			logic [IN_W:0] bitc;
			logic [IN_W:0] trial;
			if (k == 0) begin
				pv[k] = value;
				pr[k] = '0;
			end else begin
				pv[k] = rem_s[k-1];
				pr[k] = root_s[k-1];
			end
			bitc  = (IN_W+1)'(1) << (IN_W - 2 - 2 * k);
			trial = {1'b0, pr[k]} + bitc;
			if ({1'b0, pv[k]} >= trial) begin
				nv[k] = pv[k] - trial[IN_W-1:0];
				nr[k] = (pr[k] >> 1) + bitc[IN_W-1:0];
			end else begin
				nv[k] = pv[k];
				nr[k] = pr[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RW; k++) begin
				rem_s[k]  <= nv[k];
				root_s[k] <= nr[k];
			end
		end
	end

	assign root = root_s[RW-1][RW-1:0];

endmodule
`default_nettype wire

### sv/tlik_atan2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// Normalizes the vector, folds it into the right half plane and rotates it
// onto the x axis, one CORDIC iteration per register stage.
// ----------------------------------------------------------------------------
module tlik_atan2 #(
	parameter int STAGES = tlik_pkg::TLIK_CORDIC_STAGES
) (
	input  wire logic                                   clk,
	input  wire logic                                   en,
	input  wire logic signed [tlik_pkg::AT_IN_W-1:0]    y_in,
	input  wire logic signed [tlik_pkg::AT_IN_W-1:0]    x_in,
	output logic      signed [tlik_pkg::ZW-1:0]         angle
);
	import tlik_pkg::*;

	localparam int IW     = AT_IN_W;
	localparam int NORM_B = IW - 1;
	localparam int BLW    = $clog2(IW + 1);
	localparam int XW     = IW + 3;

	logic        [IW-1:0]  mag_x, mag_y, mag_any;
	logic        [BLW-1:0] blen;
	logic signed [IW-1:0]  x_s1, y_s1;
	logic        [BLW-1:0] sh_s1;
	logic                  zero_s1;

	logic signed [XW-1:0] xe, ye, xb, yb;
	logic signed [ZW-1:0] zb;

	logic signed [XW-1:0] cx [STAGES+1];
	logic signed [XW-1:0] cy [STAGES+1];
	logic signed [ZW-1:0] cz [STAGES+1];
	logic                 zf [STAGES+1];
	logic signed [XW-1:0] nx [STAGES];
	logic signed [XW-1:0] ny [STAGES];
	logic signed [ZW-1:0] nz [STAGES];

	always_comb begin
		mag_x   = x_in[IW-1] ? IW'(-x_in) : IW'(x_in);
		mag_y   = y_in[IW-1] ? IW'(-y_in) : IW'(y_in);
		mag_any = mag_x | mag_y;
		blen    = '0;
		for (int k = 0; k < IW; k++) begin
			if (mag_any[k]) begin
				blen = BLW'(k + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_in;
			y_s1    <= y_in;
			sh_s1   <= BLW'(NORM_B) - blen;
			zero_s1 <= (mag_any == '0);
		end
	end

	always_comb begin
		xe = XW'(x_s1) <<< sh_s1;
		ye = XW'(y_s1) <<< sh_s1;
		if (xe < 0) begin
			if (ye >= 0) begin
				xb = ye;
				yb = -xe;
				zb = DEG90;
			end else begin
				xb = -ye;
				yb = xe;
				zb = -DEG90;
			end
		end else begin
			xb = xe;
			yb = ye;
			zb = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < STAGES; i++) begin
			if (cy[i] > 0) begin
				nx[i] = cx[i] + (cy[i] >>> i);
				ny[i] = cy[i] - (cx[i] >>> i);
				nz[i] = cz[i] + atan_entry(i);
			end else begin
				nx[i] = cx[i] - (cy[i] >>> i);
				ny[i] = cy[i] + (cx[i] >>> i);
				nz[i] = cz[i] - atan_entry(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx[0] <= xb;
			cy[0] <= yb;
			cz[0] <= zb;
			zf[0] <= zero_s1;
			for (int i = 0; i < STAGES; i++) begin
				cx[i+1] <= nx[i];
				cy[i+1] <= ny[i];
				cz[i+1] <= nz[i];
				zf[i+1] <= zf[i];
			end
		end
	end

	assign angle = zf[STAGES] ? '0 : cz[STAGES];

endmodule
`default_nettype wire

### sv/two_link_arm_inverse_kinematics.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics
// Solves shoulder yaw, shoulder pitch and elbow pitch for a hand target.
// ----------------------------------------------------------------------------
// The block takes one target item every cycle while the output is not stalled
// and returns the joint angles of each target item in order.
// The pipeline is made of five stages of distance arithmetic, the 25-stage
// square root pipeline, two normalization stages and one CORDIC stage per
// iteration, plus the output register. When the result is not taken, the
// whole pipeline holds. Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics #(
	parameter int CORDIC_STAGES = tlik_pkg::TLIK_CORDIC_STAGES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire tlik_pkg::tlik_in_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output tlik_pkg::tlik_out_t                      out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tlik_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [tlik_pkg::COORD_W-1:0]        cfg_data
);
	import tlik_pkg::*;

	localparam int SQ_LAT    = SQ_IN_W / 2;
	localparam int AT_LAT    = 2 + CORDIC_STAGES;
	localparam int ARG_DLY   = 4 + SQ_LAT;
	localparam int REACH_DLY = SQ_LAT + AT_LAT;
	localparam int LAT       = 6 + SQ_LAT + AT_LAT;
	localparam int AW        = COORD_W + 2;

	typedef struct packed {
		logic signed [AW-1:0]      ya;
		logic signed [AW-1:0]      yb;
		logic signed [COORD_W-1:0] z;
	} args_t;

	logic                      side_q;
	logic signed [COORD_W-1:0] hand_off_q, lsx_q, rsx_q, sh_y_q, sh_z_q;
	logic        [LEN_W-1:0]   link_q;

	logic           adv;
	logic [LAT-1:0] vld_q;

	assign cfg_ready = 1'b1;
	assign adv       = !vld_q[LAT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q     <= 1'b0;
			hand_off_q <= '0;
			lsx_q      <= '0;
			rsx_q      <= '0;
			sh_y_q     <= '0;
			sh_z_q     <= '0;
			link_q     <= LEN_W'(256);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SIDE:        side_q     <= cfg_data[0];
				REG_HAND_OFFSET: hand_off_q <= signed'(cfg_data);
				REG_LEFT_SX:     lsx_q      <= signed'(cfg_data);
				REG_RIGHT_SX:    rsx_q      <= signed'(cfg_data);
				REG_SHOULDER_Y:  sh_y_q     <= signed'(cfg_data);
				REG_SHOULDER_Z:  sh_z_q     <= signed'(cfg_data);
				REG_LINK_LEN:    link_q     <= cfg_data[LEN_W-1:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic signed [AW-1:0]      off;
	logic signed [COORD_W-1:0] sx;
	logic signed [COORD_W:0]   ddx, ddy, ddz;
	logic        [COORD_W:0]   adx, ady, adz;
	args_t                     args_in;

	always_comb begin
		off        = side_q ? -AW'(hand_off_q) : AW'(hand_off_q);
		sx         = side_q ? lsx_q : rsx_q;
		args_in.ya = AW'(in_data.target_x) + off;
		args_in.yb = AW'(sh_y_q) - AW'(in_data.target_y);
		args_in.z  = in_data.target_z;
		ddx        = (COORD_W+1)'(sx) - (COORD_W+1)'(in_data.target_x);
		ddy        = (COORD_W+1)'(sh_y_q) - (COORD_W+1)'(in_data.target_y);
		ddz        = (COORD_W+1)'(sh_z_q) - (COORD_W+1)'(in_data.target_z);
		adx        = ddx[COORD_W] ? (COORD_W+1)'(-ddx) : (COORD_W+1)'(ddx);
		ady        = ddy[COORD_W] ? (COORD_W+1)'(-ddy) : (COORD_W+1)'(ddy);
		adz        = ddz[COORD_W] ? (COORD_W+1)'(-ddz) : (COORD_W+1)'(ddz);
	end

	args_t               args_s1;
	logic [COORD_W-1:0]  dx_s1, dy_s1, dz_s1, tl_s1;
	logic [31:0]         dx2_s2, dy2_s2, dz2_s2, lim_s2;
	logic [32:0]         sxy_s3;
	logic [31:0]         dz2_s3, lim_s3;
	logic [33:0]         ssum_s4;
	logic [31:0]         lim_s4;
	logic [34:0]         diff;
	logic [SQ_IN_W-1:0]  vs_s5, vr_s5;
	logic                reach_s5;

	assign diff = {3'b000, lim_s4} - {1'b0, ssum_s4};

	always_ff @(posedge clk) begin
		if (adv) begin
			args_s1  <= args_in;
			dx_s1    <= adx[COORD_W-1:0];
			dy_s1    <= ady[COORD_W-1:0];
			dz_s1    <= adz[COORD_W-1:0];
			tl_s1    <= {link_q, 1'b0};
			dx2_s2   <= 32'(dx_s1) * 32'(dx_s1);
			dy2_s2   <= 32'(dy_s1) * 32'(dy_s1);
			dz2_s2   <= 32'(dz_s1) * 32'(dz_s1);
			lim_s2   <= 32'(tl_s1) * 32'(tl_s1);
			sxy_s3   <= 33'(dx2_s2) + 33'(dy2_s2);
			dz2_s3   <= dz2_s2;
			lim_s3   <= lim_s2;
			ssum_s4  <= 34'(sxy_s3) + 34'(dz2_s3);
			lim_s4   <= lim_s3;
			reach_s5 <= diff[34];
			vs_s5    <= diff[34] ? '0 : {ssum_s4, 16'h0000};
			vr_s5    <= diff[34] ? '0 : {2'b00, diff[31:0], 16'h0000};
		end
	end

	args_t                args_d [ARG_DLY];
	logic [REACH_DLY-1:0] rch_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			args_d[0] <= args_s1;
			for (int k = 1; k < ARG_DLY; k++) begin
				args_d[k] <= args_d[k-1];
			end
			rch_q <= {rch_q[REACH_DLY-2:0], reach_s5};
		end
	end

	logic [SQ_LAT-1:0] root_s, root_r;

	tlik_isqrt #(.IN_W(SQ_IN_W)) u_sqrt_s (
		.clk   (clk),
		.en    (adv),
		.value (vs_s5),
		.root  (root_s)
	);

	tlik_isqrt #(.IN_W(SQ_IN_W)) u_sqrt_r (
		.clk   (clk),
		.en    (adv),
		.value (vr_s5),
		.root  (root_r)
	);

	logic signed [ZW-1:0] yaw_a, e1_a, e2_a;

	tlik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_yaw (
		.clk   (clk),
		.en    (adv),
		.y_in  (AT_IN_W'(args_d[ARG_DLY-1].ya)),
		.x_in  (AT_IN_W'(args_d[ARG_DLY-1].z)),
		.angle (yaw_a)
	);

	tlik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_elev (
		.clk   (clk),
		.en    (adv),
		.y_in  (AT_IN_W'(args_d[ARG_DLY-1].yb)),
		.x_in  (AT_IN_W'(args_d[ARG_DLY-1].z)),
		.angle (e1_a)
	);

	tlik_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_bend (
		.clk   (clk),
		.en    (adv),
		.y_in  (signed'({1'b0, root_r})),
		.x_in  (signed'({1'b0, root_s})),
		.angle (e2_a)
	);

	logic signed [ZW+1:0] sp_sum, ep_sum, yw_sum;

	always_comb begin
		sp_sum = (ZW+2)'(e1_a) + (ZW+2)'(e2_a) - (ZW+2)'(DEG90) + (ZW+2)'(512);
		ep_sum = (ZW+2)'(e1_a) - (ZW+2)'(e2_a) - (ZW+2)'(DEG90) + (ZW+2)'(512);
		yw_sum = (ZW+2)'(yaw_a) + (ZW+2)'(512);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.shoulder_pitch <= sp_sum[ANGLE_W+9:10];
			out_data.shoulder_yaw   <= yw_sum[ANGLE_W+9:10];
			out_data.elbow_pitch    <= ep_sum[ANGLE_W+9:10];
			out_data.beyond_reach   <= rch_q[REACH_DLY-1];
		end
	end

endmodule
`default_nettype wire
